// File: sv/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, types and helpers for the k-way timestamp merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int NUM_STREAMS  = 8;
  localparam int STREAM_DEPTH = 256;

  localparam int TIME_W = 64;
  localparam int PAY_W  = 32;
  localparam int SIDX_W = 3;

  // stream select, FIFO pointer, fill count and store address widths
  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int PW = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
  localparam int CW = $clog2(STREAM_DEPTH + 1);
  localparam int AW = SW + PW;

  localparam int LAST_STREAM = NUM_STREAMS - 1;

  // request type codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] time_v;
    logic [PAY_W-1:0]  payload;
  } ev_t;

  // compare unit controls
  typedef struct packed {
    logic          clr;
    logic          en;
    logic [SW-1:0] stream;
    logic [PW-1:0] ptr;
  } cmp_ctrl_t;

  // running winner of a scan
  typedef struct packed {
    logic          found;
    logic [SW-1:0] stream;
    logic [PW-1:0] ptr;
    ev_t           ev;
  } best_t;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(STREAM_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

endpackage

// File: sv/kwm_store.sv
// ----------------------------------------------------------------------------
// kwm_store
// Event memory for all streams: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kwm_store (
  input  logic                  clk,
  input  logic                  we,
  input  logic [kwm_pkg::AW-1:0] waddr,
  input  kwm_pkg::ev_t          wdata,
  input  logic                  re,
  input  logic [kwm_pkg::AW-1:0] raddr,
  output kwm_pkg::ev_t          rdata
);

  kwm_pkg::ev_t mem [2**kwm_pkg::AW];
  kwm_pkg::ev_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/kwm_min_unit.sv
// ----------------------------------------------------------------------------
// kwm_min_unit
// Shared 64-bit compare unit; keeps the earliest head seen during a scan.
// ----------------------------------------------------------------------------
module kwm_min_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  kwm_pkg::cmp_ctrl_t ctrl,
  input  kwm_pkg::ev_t       cand,
  output kwm_pkg::best_t     best
);

  logic                      found_r;
  logic [kwm_pkg::SW-1:0]    stream_r;
  logic [kwm_pkg::PW-1:0]    ptr_r;
  kwm_pkg::ev_t              ev_r;
  logic                      take;

  // strict less-than: on equal times the lower stream, scanned first, stays
  assign take = ctrl.en && (!found_r || (cand.time_v < ev_r.time_v));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stream_r <= ctrl.stream;
      ptr_r    <= ctrl.ptr;
      ev_r     <= cand;
    end
  end

  assign best.found  = found_r;
  assign best.stream = stream_r;
  assign best.ptr    = ptr_r;
  assign best.ev     = ev_r;

endmodule

// File: sv/kway_timestamp_merge_core.sv
// ----------------------------------------------------------------------------
// kway_timestamp_merge_core
// K-way merge of time-ordered event streams held in per-stream FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction is a push (append
//   in_event_time / in_event_payload to stream in_stream_index) or a pull
//   (remove and return the earliest head event over all streams, lowest
//   stream wins ties). in_stall is high while a transaction is in work.
//   Result channel (out_valid / out_stall): exactly one result transaction
//   per input transaction, held in an output register. A push to a full
//   stream is dropped and reported with out_overflow; a pull with nothing
//   stored returns out_out_valid = 0. out_all_empty reflects the state
//   after the transaction.
//   Sequence: a push writes the event, then the final state loads the result
//   register; a pull scans every stream, reading each non-empty head through
//   the one read port into the shared comparator, retires the winner and
//   then loads the result register. Only an idle sequencer takes a new
//   transaction. A new transaction is taken while the previous
//   result still waits in the output register; its own result then holds
//   the sequencer in the final state until that register is free.
//   Reset (rst_n low, synchronous) empties all streams; the event memory
//   itself is not cleared since only written entries are ever read.
// ----------------------------------------------------------------------------
module kway_timestamp_merge_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [kwm_pkg::SIDX_W-1:0]   in_stream_index,
  input  logic [kwm_pkg::TIME_W-1:0]   in_event_time,
  input  logic [kwm_pkg::PAY_W-1:0]    in_event_payload,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_out_valid,
  output logic [kwm_pkg::TIME_W-1:0]   out_time,
  output logic [kwm_pkg::PAY_W-1:0]    out_payload,
  output logic [kwm_pkg::SIDX_W-1:0]   out_stream,
  output logic                         out_overflow,
  output logic                         out_all_empty
);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // ready for a transaction
    S_PUSH = 6'b000010,  // write event, bump tail
    S_RD   = 6'b000100,  // issue head read for scan stream
    S_CMP  = 6'b001000,  // compare returned head
    S_POP  = 6'b010000,  // retire the winner
    S_FIN  = 6'b100000   // load result register
  } state_t;

  state_t state_r, state_nxt;

  // captured transaction
  logic                          req_pull_r;
  logic [kwm_pkg::SIDX_W-1:0]    sidx_r;
  kwm_pkg::ev_t                  push_ev_r;
  logic                          ovf_r;

  // FIFO bookkeeping
  logic [kwm_pkg::PW-1:0]        rptr_r [kwm_pkg::NUM_STREAMS];
  logic [kwm_pkg::PW-1:0]        wptr_r [kwm_pkg::NUM_STREAMS];
  logic [kwm_pkg::CW-1:0]        fill_r [kwm_pkg::NUM_STREAMS];

  logic [kwm_pkg::SW-1:0]        scan_idx_r, scan_idx_nxt;
  logic [kwm_pkg::PW-1:0]        rd_ptr_r;

  // result register
  logic                          out_valid_r;
  logic                          res_hit_r;
  logic [kwm_pkg::TIME_W-1:0]    res_time_r;
  logic [kwm_pkg::PAY_W-1:0]     res_pay_r;
  logic [kwm_pkg::SIDX_W-1:0]    res_stream_r;
  logic                          res_ovf_r;
  logic                          res_empty_r;

  logic                          in_acc;
  logic                          sidx_ok;
  logic [kwm_pkg::SW-1:0]        sidx_s;
  logic [kwm_pkg::SW-1:0]        idx_sel;
  logic [kwm_pkg::CW-1:0]        fill_sel;
  logic [kwm_pkg::PW-1:0]        head_ptr;
  logic [kwm_pkg::PW-1:0]        tail_ptr;
  logic                          push_full;
  logic                          push_do;
  logic                          pop_do;
  logic                          rd_en;
  logic                          scan_last;
  logic                          res_load;
  logic                          hit;
  logic                          empty_all;

  kwm_pkg::ev_t                  rd_ev;
  kwm_pkg::cmp_ctrl_t            cmp_ctrl;
  kwm_pkg::best_t                best;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign res_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Stream select: one index into the bookkeeping arrays per cycle
  // --------------------------------------------------------------------------
  // pushes beyond the implemented streams are silently ignored
  assign sidx_ok = (int'(sidx_r) < kwm_pkg::NUM_STREAMS);
  assign sidx_s  = kwm_pkg::SW'(sidx_r);

  always_comb begin
    case (state_r)
      S_PUSH:  idx_sel = sidx_s;
      S_POP:   idx_sel = best.stream;
      default: idx_sel = scan_idx_r;
    endcase
  end

  assign fill_sel  = fill_r[idx_sel];
  assign head_ptr  = rptr_r[idx_sel];
  assign tail_ptr  = wptr_r[idx_sel];

  assign push_full = (fill_sel == kwm_pkg::CW'(kwm_pkg::STREAM_DEPTH));
  assign push_do   = (state_r == S_PUSH) && sidx_ok && !push_full;
  assign pop_do    = (state_r == S_POP) && best.found;
  // empty streams are skipped without a memory read
  assign rd_en     = (state_r == S_RD) && (fill_sel != '0);
  assign scan_last = (scan_idx_r == kwm_pkg::SW'(kwm_pkg::LAST_STREAM));

  always_comb begin
    empty_all = 1'b1;
    for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++) begin
      if (fill_r[s] != '0) empty_all = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Event memory and shared compare unit
  // --------------------------------------------------------------------------
  kwm_store u_store (
    .clk   (clk),
    .we    (push_do),
    .waddr ({sidx_s, tail_ptr}),
    .wdata (push_ev_r),
    .re    (rd_en),
    .raddr ({scan_idx_r, head_ptr}),
    .rdata (rd_ev)
  );

  assign cmp_ctrl.clr    = in_acc;
  assign cmp_ctrl.en     = (state_r == S_CMP);
  assign cmp_ctrl.stream = scan_idx_r;
  assign cmp_ctrl.ptr    = rd_ptr_r;

  kwm_min_unit u_min (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cmp_ctrl),
    .cand  (rd_ev),
    .best  (best)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          scan_idx_nxt = '0;
          state_nxt    = (in_req_type == kwm_pkg::REQ_PULL) ? S_RD : S_PUSH;
        end
      end
      S_PUSH: begin
        state_nxt = S_FIN;
      end
      S_RD: begin
        if (rd_en) begin
          state_nxt = S_CMP;
        end else if (scan_last) begin
          state_nxt = S_POP;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_CMP: begin
        if (scan_last) begin
          state_nxt = S_POP;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_POP: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  // captured request and head pointer of the read in flight
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_pull_r        <= (in_req_type == kwm_pkg::REQ_PULL);
      sidx_r            <= in_stream_index;
      push_ev_r.time_v  <= in_event_time;
      push_ev_r.payload <= in_event_payload;
    end
    if (rd_en) rd_ptr_r <= head_ptr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (in_acc) begin
      ovf_r <= 1'b0;
    end else if (state_r == S_PUSH) begin
      ovf_r <= sidx_ok && push_full;
    end
  end

  // --------------------------------------------------------------------------
  // FIFO pointers and fill counts
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++) begin
        rptr_r[s] <= '0;
        wptr_r[s] <= '0;
        fill_r[s] <= '0;
      end
    end else begin
      if (push_do) begin
        wptr_r[sidx_s] <= kwm_pkg::next_ptr(tail_ptr);
        fill_r[sidx_s] <= fill_sel + 1'b1;
      end
      if (pop_do) begin
        rptr_r[best.stream] <= kwm_pkg::next_ptr(best.ptr);
        fill_r[best.stream] <= fill_sel - 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign hit = req_pull_r && best.found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_hit_r    <= hit;
      res_time_r   <= hit ? best.ev.time_v : '0;
      res_pay_r    <= hit ? best.ev.payload : '0;
      res_stream_r <= hit ? kwm_pkg::SIDX_W'(best.stream) : '0;
      res_ovf_r    <= ovf_r;
      res_empty_r  <= empty_all;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_valid = res_hit_r;
  assign out_time      = res_time_r;
  assign out_payload   = res_pay_r;
  assign out_stream    = res_stream_r;
  assign out_overflow  = res_ovf_r;
  assign out_all_empty = res_empty_r;

`ifndef SYNTH
  // the winner being retired must still hold an event
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_do |-> (fill_sel != '0))
    else $error("pop from empty stream");

  // a compare step always consumes a read issued the cycle before
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> $past(rd_en))
    else $error("compare without head read");

  // a new result only appears out of the final state
  a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside final state");

  // a delivered event and an overflow never share a result
  a_hit_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_hit_r && res_ovf_r))
    else $error("event and overflow in one result");
`endif

endmodule

// File: sim/merge_order_checker.sv
// ----------------------------------------------------------------------------
// merge_order_checker
// Predicts and checks the result stream of the k-way timestamp merge core.
// Keeps its own copy of the per-stream event FIFOs, works out the expected
// result of every accepted input transaction, and compares each accepted
// result transaction against the oldest expected one.
// ----------------------------------------------------------------------------
module merge_order_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [kwm_pkg::SIDX_W-1:0] in_stream_index,
  input  logic [kwm_pkg::TIME_W-1:0] in_event_time,
  input  logic [kwm_pkg::PAY_W-1:0]  in_event_payload,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_out_valid,
  input  logic [kwm_pkg::TIME_W-1:0] out_time,
  input  logic [kwm_pkg::PAY_W-1:0]  out_payload,
  input  logic [kwm_pkg::SIDX_W-1:0] out_stream,
  input  logic                       out_overflow,
  input  logic                       out_all_empty,
  output int                         fail_count,
  output int                         pending,
  output int                         push_count,
  output int                         drop_count,
  output int                         pull_count,
  output int                         delivered_count,
  output int                         tie_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                       has_event;
    logic [kwm_pkg::TIME_W-1:0] stamp;
    logic [kwm_pkg::PAY_W-1:0]  handle;
    logic [kwm_pkg::SIDX_W-1:0] stream;
    logic                       dropped;
    logic                       drained;
  } merge_result_t;

  kwm_pkg::ev_t  stream_mem [kwm_pkg::NUM_STREAMS][kwm_pkg::STREAM_DEPTH];
  int unsigned   head_ptr   [kwm_pkg::NUM_STREAMS];
  int unsigned   tail_ptr   [kwm_pkg::NUM_STREAMS];
  int unsigned   held       [kwm_pkg::NUM_STREAMS];
  merge_result_t expected_events [$];

  task automatic merge_predict(input logic req, input logic [kwm_pkg::SIDX_W-1:0] sidx,
                               input logic [kwm_pkg::TIME_W-1:0] stamp,
                               input logic [kwm_pkg::PAY_W-1:0] handle,
                               output merge_result_t r);
    int best;
    int same;
    r = '0;
    best = -1;
    same = 0;
    if (req == kwm_pkg::REQ_PUSH) begin
      push_count++;
      if (int'(sidx) < kwm_pkg::NUM_STREAMS) begin
        if (held[sidx] >= kwm_pkg::STREAM_DEPTH) begin
          r.dropped = 1'b1;
          drop_count++;
        end else begin
          stream_mem[sidx][tail_ptr[sidx]] = '{time_v: stamp, payload: handle};
          tail_ptr[sidx] = (tail_ptr[sidx] + 1) % kwm_pkg::STREAM_DEPTH;
          held[sidx]++;
        end
      end
    end else begin
      pull_count++;
      // strict less-than keeps the lowest stream on equal heads
      for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++)
        if (held[s] != 0 && (best < 0 ||
            stream_mem[s][head_ptr[s]].time_v < stream_mem[best][head_ptr[best]].time_v))
          best = s;
      if (best >= 0) begin
        for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++)
          if (held[s] != 0 &&
              stream_mem[s][head_ptr[s]].time_v == stream_mem[best][head_ptr[best]].time_v)
            same++;
        if (same > 1) tie_count++;
        r.has_event = 1'b1;
        r.stamp     = stream_mem[best][head_ptr[best]].time_v;
        r.handle    = stream_mem[best][head_ptr[best]].payload;
        r.stream    = kwm_pkg::SIDX_W'(best);
        head_ptr[best] = (head_ptr[best] + 1) % kwm_pkg::STREAM_DEPTH;
        held[best]--;
        delivered_count++;
      end
    end
    r.drained = 1'b1;
    for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++)
      if (held[s] != 0) r.drained = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    merge_result_t want;
    merge_result_t got;
    if (!rst_n) begin
      for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++) begin
        head_ptr[s] = 0;
        tail_ptr[s] = 0;
        held[s]     = 0;
      end
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{has_event: out_out_valid, stamp: out_time, handle: out_payload,
                stream: out_stream, dropped: out_overflow, drained: out_all_empty};
        if (expected_events.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: valid=%b time=%h pay=%h",
                     $realtime, got.has_event, got.stamp, got.handle);
        end else begin
          want = expected_events.pop_front();
          if (got.has_event !== want.has_event || got.stamp !== want.stamp ||
              got.handle !== want.handle || got.stream !== want.stream ||
              got.dropped !== want.dropped || got.drained !== want.drained) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch exp valid=%b time=%h pay=%h strm=%0d ovf=%b empty=%b",
                       $realtime, want.has_event, want.stamp, want.handle, want.stream,
                       want.dropped, want.drained);
              $display("%0t:          got valid=%b time=%h pay=%h strm=%0d ovf=%b empty=%b",
                       $realtime, got.has_event, got.stamp, got.handle, got.stream,
                       got.dropped, got.drained);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        merge_predict(in_req_type, in_stream_index, in_event_time, in_event_payload, want);
        expected_events.insert(expected_events.size(), want);
      end
    end
    pending <= expected_events.size();
  end

endmodule

// File: sim/kway_timestamp_merge_core_tb.sv
// ----------------------------------------------------------------------------
// kway_timestamp_merge_core_tb
// Stimulus and verdict for the k-way timestamp merge core. Drives push and
// pull transactions (directed corners, then ordered streams, a stream filled
// past its depth, and unordered noise) with bursty input and a stalling
// receiver; merge_order_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module kway_timestamp_merge_core_tb;

  // The limit leaves a wide margin over the slowest pull for sender gaps,
  // receiver stalls and the long hold-off.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_START   = 3000;
  localparam int HOLD_CYCLES  = 400;

  logic                       clk              = 1'b0;
  logic                       rst_n            = 1'b0;
  logic                       in_valid         = 1'b0;
  logic                       in_req_type      = kwm_pkg::REQ_PUSH;
  logic [kwm_pkg::SIDX_W-1:0] in_stream_index  = '0;
  logic [kwm_pkg::TIME_W-1:0] in_event_time    = '0;
  logic [kwm_pkg::PAY_W-1:0]  in_event_payload = '0;
  logic                       out_stall        = 1'b0;

  logic                       in_stall;
  logic                       out_valid;
  logic                       out_out_valid;
  logic [kwm_pkg::TIME_W-1:0] out_time;
  logic [kwm_pkg::PAY_W-1:0]  out_payload;
  logic [kwm_pkg::SIDX_W-1:0] out_stream;
  logic                       out_overflow;
  logic                       out_all_empty;

  int fail_count, pending, push_count, drop_count, pull_count, delivered_count, tie_count;
  int cycle_count = 0;

  // sender burst bookkeeping and per-stream running timestamps
  int                         burst_left = 0;
  logic [kwm_pkg::TIME_W-1:0] next_stamp [kwm_pkg::NUM_STREAMS];

  always #2 clk = ~clk;

  kway_timestamp_merge_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_stream_index  (in_stream_index),
    .in_event_time    (in_event_time),
    .in_event_payload (in_event_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_valid    (out_out_valid),
    .out_time         (out_time),
    .out_payload      (out_payload),
    .out_stream       (out_stream),
    .out_overflow     (out_overflow),
    .out_all_empty    (out_all_empty)
  );

  merge_order_checker order_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_stream_index  (in_stream_index),
    .in_event_time    (in_event_time),
    .in_event_payload (in_event_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_valid    (out_out_valid),
    .out_time         (out_time),
    .out_payload      (out_payload),
    .out_stream       (out_stream),
    .out_overflow     (out_overflow),
    .out_all_empty    (out_all_empty),
    .fail_count       (fail_count),
    .pending          (pending),
    .push_count       (push_count),
    .drop_count       (drop_count),
    .pull_count       (pull_count),
    .delivered_count  (delivered_count),
    .tie_count        (tie_count)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one transaction and return at the edge where it is taken.
  // Between bursts valid may drop for a random gap; inside a burst valid stays
  // high and only the payload moves on, so valid gets one assignment per edge.
  task automatic send_txn(input logic req, input logic [kwm_pkg::SIDX_W-1:0] sidx,
                          input logic [kwm_pkg::TIME_W-1:0] stamp,
                          input logic [kwm_pkg::PAY_W-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_stream_index  <= sidx;
    in_event_time    <= stamp;
    in_event_payload <= handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Push onto stream s. Ordered pushes creep forward in small steps so that
  // heads of different streams often carry equal timestamps; scrambled pushes
  // use a full-width random time and break the stream's order.
  task automatic push_ordered(input int s, input bit scramble);
    logic [kwm_pkg::TIME_W-1:0] stamp;
    if (scramble) begin
      stamp = {$urandom, $urandom};
    end else begin
      if ($urandom_range(0, 31) == 0) next_stamp[s] += $urandom_range(1, 50);
      else next_stamp[s] += $urandom_range(0, 3);
      stamp = next_stamp[s];
    end
    send_txn(kwm_pkg::REQ_PUSH, kwm_pkg::SIDX_W'(s), stamp, $urandom);
  endtask

  // Pull; the ignored fields still carry random bits.
  task automatic pull_earliest();
    send_txn(kwm_pkg::REQ_PULL, kwm_pkg::SIDX_W'($urandom_range(0, kwm_pkg::NUM_STREAMS - 1)),
             {$urandom, $urandom}, $urandom);
  endtask

  // Receiver: stall pattern changes in random segments (never, light, heavy,
  // toggling). Once, well into the run, it holds off for a long stretch so
  // that the core keeps a finished result and backs up its input.
  initial begin : receiver
    int seg_left;
    int mode;
    seg_left = 0;
    mode     = 0;
    forever begin
      @(posedge clk);
      if (cycle_count == HOLD_START) begin
        for (int held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 64);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin : stimulus
    int fill_stream;
    for (int s = 0; s < kwm_pkg::NUM_STREAMS; s++) next_stamp[s] = $urandom_range(0, 8);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners.
    pull_earliest();                                                // nothing stored
    send_txn(kwm_pkg::REQ_PUSH, 3'd0, '0, '0);                      // smallest time, payload
    send_txn(kwm_pkg::REQ_PUSH, 3'd7, '1, '1);                      // largest time, payload
    send_txn(kwm_pkg::REQ_PUSH, 3'd3, 64'd5, 32'h0000_00a3);
    send_txn(kwm_pkg::REQ_PUSH, 3'd5, 64'd5, 32'h0000_00a5);
    send_txn(kwm_pkg::REQ_PUSH, 3'd1, 64'd5, 32'h0000_00a1);        // three-way tie at 5
    pull_earliest();                                                // stream 0, time 0
    pull_earliest();                                                // tie: stream 1
    pull_earliest();                                                // tie: stream 3
    pull_earliest();                                                // stream 5
    send_txn(kwm_pkg::REQ_PUSH, 3'd2, '1, 32'h5555_5555);           // tie at the top value
    pull_earliest();                                                // stream 2 before 7
    pull_earliest();                                                // stream 7, all empty
    pull_earliest();                                                // empty again
    send_txn(kwm_pkg::REQ_PUSH, 3'd4, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_txn(kwm_pkg::REQ_PUSH, 3'd4, 64'd1, 32'h7fff_ffff);        // FIFO order, not sorted
    send_txn(kwm_pkg::REQ_PUSH, 3'd6, 64'd2, 32'haaaa_aaaa);
    send_txn(kwm_pkg::REQ_PUSH, 3'd6, 64'h7fff_ffff_ffff_ffff, 32'h0f0f_0f0f);
    pull_earliest();                                                // stream 6, time 2
    pull_earliest();                                                // stream 6 high time
    pull_earliest();                                                // stream 4 head
    pull_earliest();                                                // stream 4, time 1

    // Ordered streams merged with pulls, a tenth of pushes out of order.
    repeat (700) begin
      if ($urandom_range(0, 99) < 55)
        push_ordered($urandom_range(0, kwm_pkg::NUM_STREAMS - 1), $urandom_range(0, 9) == 0);
      else
        pull_earliest();
    end

    // Fill one stream past its depth to force drops, then drain through it
    // with a few pushes mixed in; the pointers of that stream wrap.
    fill_stream = $urandom_range(0, kwm_pkg::NUM_STREAMS - 1);
    repeat (300) begin
      if ($urandom_range(0, 9) == 0)
        push_ordered($urandom_range(0, kwm_pkg::NUM_STREAMS - 1), 1'b0);
      else
        push_ordered(fill_stream, 1'b0);
    end
    repeat (320) begin
      if ($urandom_range(0, 6) == 0)
        push_ordered($urandom_range(0, kwm_pkg::NUM_STREAMS - 1), 1'b0);
      else
        pull_earliest();
    end

    // Unordered noise over the full time range.
    repeat (500) begin
      if ($urandom_range(0, 1) == 0)
        push_ordered($urandom_range(0, kwm_pkg::NUM_STREAMS - 1), 1'b1);
      else
        pull_earliest();
    end

    // Empty the streams; late pulls hit the empty case.
    repeat (150) pull_earliest();
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pushes (%0d dropped on a full stream) and %0d pulls",
             push_count, drop_count, pull_count);
    $display("%0d pulls delivered an event, %0d of them picked among equal head times",
             delivered_count, tie_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
